FILE: sv/cfis_pkg.sv
// Package: shared types, constants and state codes for the column cell splitter.
package cfis_pkg;

    // Default sizing
    localparam int MAX_ROWS_DEF      = 1024;
    localparam int MAX_INTERVALS_DEF = 32;

    // Fixed field widths
    localparam int OCC_W     = 8;
    localparam int ROWS_W    = 11;
    localparam int THR_W     = 8;
    localparam int ROW_OUT_W = 10;
    localparam int IV_W      = 2 * ROW_OUT_W;
    localparam int COL_W     = 16;
    localparam int CELL_W    = 16;
    localparam int ROW_CMP_W = 13;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 11;

    // Reset values of the registers
    localparam logic [ROWS_W-1:0] ROWS_RESET   = 11'd1024;
    localparam logic [THR_W-1:0]  THRESH_RESET = 8'd100;

    // Reserved saturated cell number
    localparam logic [CELL_W-1:0] CELL_SAT = 16'hFFFF;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE    = 4'd0,
        REG_FREE_THRESHOLD = 4'd1
    } cfg_reg_t;

    // Pixel item
    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic             map_start;
    } pix_t;

    // Interval result item
    typedef struct packed {
        logic [COL_W-1:0]     column;
        logic [ROW_OUT_W-1:0] start_row;
        logic [ROW_OUT_W-1:0] end_row;
        logic [CELL_W-1:0]    cell_index;
        logic                 new_cell;
        logic                 last_interval;
        logic                 overflow;
    } res_t;

    // Configuration write item
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_t;

    // Events from the run tracker to the sequencer
    typedef struct packed {
        logic            wr_en;
        logic [IV_W-1:0] wr_data;
        logic            col_end;
        logic            map_start;
        logic            overflow;
    } trk_evt_t;

    // Column-end sequencer states
    typedef enum logic [2:0] {
        S_PIXEL,
        S_CHECK,
        S_CMP_RD,
        S_CMP_CHK,
        S_EVAL,
        S_EMIT_RD,
        S_EMIT_LD,
        S_DONE
    } seq_state_t;

endpackage

FILE: sv/cfis_stream_if.sv
// Interface: valid/ready channel carrying one payload item.
interface cfis_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/cfis_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfis_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/cfis_run_tracker.sv
// Run tracker: follows free runs down a column and produces interval writes.
module cfis_run_tracker #(
    parameter int MAX_ROWS      = 1024,
    parameter int MAX_INTERVALS = 32,
    parameter int ROW_W         = $clog2(MAX_ROWS),
    parameter int CNT_W         = $clog2(MAX_INTERVALS + 1),
    parameter int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  cfis_pkg::pix_t                pix,
    input  logic [cfis_pkg::ROWS_W-1:0]   rows_in_use,
    input  logic [cfis_pkg::THR_W-1:0]    free_threshold,
    input  logic                          clear,
    output cfis_pkg::trk_evt_t            evt,
    output logic [AW-1:0]                 wr_addr,
    output logic [CNT_W-1:0]              cur_count
);
    import cfis_pkg::*;

    logic [ROW_W-1:0] row_reg, row_next;
    logic             run_reg, run_next;
    logic [ROW_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic [ROW_W-1:0]     row_e;
    logic                 run_e;
    logic [ROW_W-1:0]     start_e;
    logic [CNT_W-1:0]     cnt_e;
    logic                 ovf_e;
    logic [ROW_CMP_W-1:0] rows_c;
    logic                 free_px;
    logic                 end_col;
    logic                 store;
    logic [ROW_W-1:0]     first_row;
    logic [ROW_W-1:0]     last_row;
    logic                 room;

    // Effective row count, clamped to 1..MAX_ROWS
    always_comb
    begin
        if (rows_in_use == '0)
        begin
            rows_c = ROW_CMP_W'(1);
        end
        else if (ROW_CMP_W'(rows_in_use) > ROW_CMP_W'(MAX_ROWS))
        begin
            rows_c = ROW_CMP_W'(MAX_ROWS);
        end
        else
        begin
            rows_c = ROW_CMP_W'(rows_in_use);
        end
    end

    // Per-pixel run logic; map start clears the partial column first
    always_comb
    begin
        row_e   = pix.map_start ? '0 : row_reg;
        run_e   = pix.map_start ? 1'b0 : run_reg;
        start_e = pix.map_start ? '0 : start_reg;
        cnt_e   = pix.map_start ? '0 : cnt_reg;
        ovf_e   = pix.map_start ? 1'b0 : ovf_reg;

        free_px = pix.occupancy < free_threshold;
        end_col = (ROW_CMP_W'(row_e) + ROW_CMP_W'(1)) >= rows_c;

        store     = 1'b0;
        first_row = start_e;
        last_row  = row_e;
        if (!free_px && run_e)
        begin
            store    = 1'b1;
            last_row = row_e - ROW_W'(1);
        end
        else if (free_px && end_col)
        begin
            store     = 1'b1;
            first_row = run_e ? start_e : row_e;
        end
        room = cnt_e < CNT_W'(MAX_INTERVALS);

        row_next   = row_reg;
        run_next   = run_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            cnt_next = cnt_e;
            ovf_next = ovf_e;
            if (store && room)
            begin
                cnt_next = cnt_e + CNT_W'(1);
            end
            else if (store)
            begin
                ovf_next = 1'b1;
            end
            if (end_col)
            begin
                row_next   = '0;
                run_next   = 1'b0;
                start_next = '0;
            end
            else
            begin
                row_next   = row_e + ROW_W'(1);
                run_next   = free_px;
                start_next = (free_px && !run_e) ? row_e : start_e;
            end
        end
        else if (clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            run_reg   <= 1'b0;
            start_reg <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            run_reg   <= run_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Events to the sequencer
    always_comb
    begin
        evt.wr_en     = accept && store && room;
        evt.wr_data   = {ROW_OUT_W'(first_row), ROW_OUT_W'(last_row)};
        evt.col_end   = accept && end_col;
        evt.map_start = accept && pix.map_start;
        evt.overflow  = ovf_reg;
    end
    assign wr_addr   = cnt_e[AW-1:0];
    assign cur_count = cnt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_INTERVALS))
        else $error("interval count beyond bound");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        evt.wr_en |=> cnt_reg == $past(cnt_e) + CNT_W'(1))
        else $error("interval write without count step");
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && store && !room) |=> ovf_reg)
        else $error("dropped interval did not set overflow");
endmodule

FILE: sv/column_free_interval_cell_split.sv
// Top level: column free-interval cell splitter with ping-pong interval memories.
//
//  channel  | dir | handshake     | item
//  ---------+-----+---------------+---------------------------------------------
//  pixel    | in  | valid/ready   | occupancy, map_start
//  result   | out | valid/ready   | column, start_row, end_row, cell_index,
//           |     |               | new_cell, last_interval, overflow
//  cfg      | in  | valid/ready   | index, data (0 rows_in_use, 1 free_threshold)
//
// Pixels go in at one per cycle while a column is scanned. At the last row the
// sequencer compares current and previous interval memories (interval by interval,
// stopping at the first difference), then reads and emits the current intervals
// (waiting while result is stalled); pixel.ready is low meanwhile. The last result may
// wait in the output register while the next column streams. No clearing pass after
// reset; cfg is always ready.
module column_free_interval_cell_split #(
    parameter int MAX_ROWS      = cfis_pkg::MAX_ROWS_DEF,
    parameter int MAX_INTERVALS = cfis_pkg::MAX_INTERVALS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cfis_stream_if.sink   pixel,
    cfis_stream_if.source result,
    cfis_stream_if.sink   cfg
);
    import cfis_pkg::*;

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    // Configuration registers
    logic [ROWS_W-1:0] rows_reg;
    logic [THR_W-1:0]  thresh_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= ROWS_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_ROWS_IN_USE:    rows_reg   <= cfg.payload.data[ROWS_W-1:0];
                REG_FREE_THRESHOLD: thresh_reg <= cfg.payload.data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Run tracker
    trk_evt_t         evt;
    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] cur_count;
    logic             pix_accept;
    logic             trk_clear;

    assign pix_accept = pixel.valid && pixel.ready;

    cfis_run_tracker #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (pix_accept),
        .pix            (pixel.payload),
        .rows_in_use    (rows_reg),
        .free_threshold (thresh_reg),
        .clear          (trk_clear),
        .evt            (evt),
        .wr_addr        (wr_addr),
        .cur_count      (cur_count)
    );

    // Ping-pong interval memories; bank_reg selects the current one
    logic            bank_reg, bank_next;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [IV_W-1:0] rd_a, rd_b;
    logic [IV_W-1:0] cur_rd, prev_rd;

    cfis_ram #(.WIDTH(IV_W), .DEPTH(MAX_INTERVALS)) u_ram_a (
        .clk   (clk),
        .we    (evt.wr_en && !bank_reg),
        .waddr (wr_addr),
        .wdata (evt.wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_a)
    );

    cfis_ram #(.WIDTH(IV_W), .DEPTH(MAX_INTERVALS)) u_ram_b (
        .clk   (clk),
        .we    (evt.wr_en && bank_reg),
        .waddr (wr_addr),
        .wdata (evt.wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_b)
    );

    assign cur_rd  = bank_reg ? rd_b : rd_a;
    assign prev_rd = bank_reg ? rd_a : rd_b;

    // Sequencer registers
    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] prev_cnt_reg, prev_cnt_next;
    logic             same_reg, same_next;
    logic             ovf_col_reg, ovf_col_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    logic             last_idx;
    logic             mismatch;
    logic             out_load;
    logic             sat_col;

    assign last_idx = (idx_reg + CNT_W'(1)) == cur_count;
    assign mismatch = cur_rd != prev_rd;
    assign sat_col  = !same_reg && (cur_count != '0)
                      && ((17'(cell_reg) + 17'(cur_count)) > 17'(CELL_SAT));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_PIXEL:
            begin
                if (evt.col_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((cur_count != prev_cnt_reg) || (cur_count == '0))
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                state_next = (mismatch || last_idx) ? S_EVAL : S_CMP_RD;
            end
            S_EVAL:
            begin
                state_next = (cur_count == '0) ? S_DONE : S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (out_load)
                begin
                    state_next = last_idx ? S_DONE : S_EMIT_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_PIXEL;
            end
            default:
            begin
                state_next = S_PIXEL;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        pixel.ready = (state_reg == S_PIXEL);
        ram_re      = (state_reg == S_CMP_RD) || (state_reg == S_EMIT_RD);
        ram_raddr   = idx_reg[AW-1:0];
        trk_clear   = (state_reg == S_DONE);
        out_load    = (state_reg == S_EMIT_LD) && (!out_valid_reg || result.ready);
    end

    // Datapath next values
    always_comb
    begin
        idx_next       = idx_reg;
        prev_cnt_next  = prev_cnt_reg;
        same_next      = same_reg;
        ovf_col_next   = ovf_col_reg;
        cell_next      = cell_reg;
        col_next       = col_reg;
        bank_next      = bank_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        // map start clears history and counters
        if (evt.map_start)
        begin
            prev_cnt_next = '0;
            cell_next     = '0;
            col_next      = '0;
        end

        case (state_reg)
            S_CHECK:
            begin
                same_next = (cur_count == prev_cnt_reg);
                idx_next  = '0;
            end
            S_CMP_CHK:
            begin
                if (mismatch)
                begin
                    same_next = 1'b0;
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            S_EVAL:
            begin
                ovf_col_next = evt.overflow || sat_col;
                idx_next     = '0;
            end
            S_EMIT_LD:
            begin
                if (out_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.column       = col_reg;
                    out_next.start_row    = cur_rd[IV_W-1:ROW_OUT_W];
                    out_next.end_row      = cur_rd[ROW_OUT_W-1:0];
                    out_next.new_cell     = !same_reg;
                    out_next.last_interval = last_idx;
                    out_next.overflow     = ovf_col_reg;
                    if (same_reg)
                    begin
                        out_next.cell_index = cell_reg - CELL_W'(prev_cnt_reg)
                                              + CELL_W'(idx_reg);
                    end
                    else if (cell_reg != CELL_SAT)
                    begin
                        out_next.cell_index = cell_reg;
                        cell_next           = cell_reg + CELL_W'(1);
                    end
                    else
                    begin
                        out_next.cell_index = CELL_SAT;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                bank_next     = !bank_reg;
                prev_cnt_next = cur_count;
                col_next      = col_reg + COL_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_PIXEL;
            idx_reg       <= '0;
            prev_cnt_reg  <= '0;
            same_reg      <= 1'b0;
            ovf_col_reg   <= 1'b0;
            cell_reg      <= '0;
            col_reg       <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            prev_cnt_reg  <= prev_cnt_next;
            same_reg      <= same_next;
            ovf_col_reg   <= ovf_col_next;
            cell_reg      <= cell_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    a_no_new_when_same: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && same_reg) |=> !result.payload.new_cell)
        else $error("extending interval flagged as new cell");
    a_cell_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !same_reg && cell_reg != CELL_SAT) |=> cell_reg == $past(cell_reg) + 16'd1)
        else $error("cell counter did not advance on new cell");
    a_cell_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PIXEL) |=> cell_reg >= $past(cell_reg))
        else $error("cell counter went backwards");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(out_reg))
        else $error("stalled result overwritten");
endmodule

FILE: verif/tb_column_free_interval_cell_split.sv
// Testbench for column_free_interval_cell_split: pixel stimulus, interval prediction and checks.
module tb_column_free_interval_cell_split;
    timeunit 1ns;
    timeprecision 1ps;

    import cfis_pkg::*;

    localparam int ROW_LIMIT    = MAX_ROWS_DEF;
    localparam int IV_LIMIT     = MAX_INTERVALS_DEF;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN        = 100;
    localparam int RANDOM_ITEMS = 140;
    localparam int REPORT_CAP   = 40;
    localparam int unsigned LIMIT = 100_000;

    // Predicts the interval items of each column and checks the block's output
    class interval_board;
        logic [ROWS_W-1:0]    rows_reg;
        logic [THR_W-1:0]     thr_reg;
        logic [ROW_OUT_W-1:0] row_pos;
        logic [ROW_OUT_W-1:0] run_first;
        logic [COL_W-1:0]     col_pos;
        logic [CELL_W-1:0]    next_cell;
        logic [5:0]           cur_n;
        logic [5:0]           prev_n;
        logic                 in_run;
        logic                 dropped;
        logic [IV_W-1:0]      cur_iv [IV_LIMIT];
        logic [IV_W-1:0]      prev_iv [IV_LIMIT];
        res_t                 due_intervals [$];
        int unsigned          mismatches;
        int unsigned          intervals_checked;
        int unsigned          new_cells;
        int unsigned          flagged;
        int unsigned          columns_done;

        function new();
            rows_reg          = ROWS_RESET;
            thr_reg           = THRESH_RESET;
            mismatches        = 0;
            intervals_checked = 0;
            new_cells         = 0;
            flagged           = 0;
            columns_done      = 0;
            clear_map();
        endfunction

        function void clear_map();
            row_pos   = '0;
            col_pos   = '0;
            in_run    = 1'b0;
            run_first = '0;
            cur_n     = '0;
            prev_n    = '0;
            next_cell = '0;
            dropped   = 1'b0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                REG_ROWS_IN_USE:    rows_reg = d[ROWS_W-1:0];
                REG_FREE_THRESHOLD: thr_reg  = d[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Intervals past the store depth are lost and flag the column
        function void keep_interval(logic [ROW_OUT_W-1:0] first_row,
                                    logic [ROW_OUT_W-1:0] last_row);
            if (cur_n < IV_LIMIT)
            begin
                cur_iv[cur_n[$clog2(IV_LIMIT)-1:0]] = {first_row, last_row};
                cur_n++;
            end
            else
                dropped = 1'b1;
        endfunction

        function int pending();
            return due_intervals.size();
        endfunction

        function void take_pixel(pix_t p);
            logic [ROWS_W-1:0] rows;
            logic              is_free;
            logic              same;
            logic [CELL_W-1:0] idx;
            res_t              col_res [$];
            res_t              r;
            if (p.map_start)
                clear_map();
            rows = rows_reg;
            if (rows < 1)
                rows = ROWS_W'(1);
            if (rows > ROW_LIMIT)
                rows = ROWS_W'(ROW_LIMIT);

            // run tracking
            is_free = p.occupancy < thr_reg;
            if (is_free && !in_run)
            begin
                in_run    = 1'b1;
                run_first = row_pos;
            end
            else if (!is_free && in_run)
            begin
                in_run = 1'b0;
                keep_interval(run_first, row_pos - 1'b1);
            end
            if ({1'b0, row_pos} + 1 < rows)
            begin
                row_pos++;
                return;
            end

            // column end: compare with the previous column, then number the cells
            if (in_run)
                keep_interval(run_first, row_pos);
            same = (cur_n == prev_n);
            for (int i = 0; same && i < cur_n; i++)
                if (cur_iv[i] != prev_iv[i])
                    same = 1'b0;
            for (int i = 0; i < cur_n; i++)
            begin
                if (same)
                    idx = next_cell - CELL_W'(prev_n) + CELL_W'(i);
                else if (next_cell != CELL_SAT)
                begin
                    idx = next_cell;
                    next_cell++;
                end
                else
                begin
                    idx     = CELL_SAT;
                    dropped = 1'b1;
                end
                r.column        = col_pos;
                r.start_row     = cur_iv[i][IV_W-1:ROW_OUT_W];
                r.end_row       = cur_iv[i][ROW_OUT_W-1:0];
                r.cell_index    = idx;
                r.new_cell      = !same;
                r.last_interval = (i + 1 == cur_n);
                r.overflow      = 1'b0;
                col_res.insert(col_res.size(), r);
            end
            // the flag covers every item of the column, including earlier ones
            foreach (col_res[k])
            begin
                col_res[k].overflow = dropped;
                if (col_res[k].new_cell)
                    new_cells++;
                if (dropped)
                    flagged++;
                due_intervals.insert(due_intervals.size(), col_res[k]);
            end
            prev_iv = cur_iv;
            prev_n  = cur_n;
            cur_n   = '0;
            in_run  = 1'b0;
            run_first = '0;
            row_pos = '0;
            col_pos++;
            dropped = 1'b0;
            columns_done++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_interval(res_t got);
            res_t want;
            if (due_intervals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $error("interval item with none expected: column %0d, rows %0d..%0d",
                           got.column, got.start_row, got.end_row);
                return;
            end
            want = due_intervals.pop_front();
            intervals_checked++;
            compare_field("column", want.column, got.column);
            compare_field("start_row", want.start_row, got.start_row);
            compare_field("end_row", want.end_row, got.end_row);
            compare_field("cell_index", want.cell_index, got.cell_index);
            compare_field("new_cell", want.new_cell, got.new_cell);
            compare_field("last_interval", want.last_interval, got.last_interval);
            compare_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cfis_stream_if #(.payload_t(pix_t)) pixel_if ();
    cfis_stream_if #(.payload_t(res_t)) result_if ();
    cfis_stream_if #(.payload_t(cfg_t)) cfg_if ();

    column_free_interval_cell_split dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    interval_board     board = new();
    bit                steady;
    logic [THR_W-1:0]  thr_now;
    int unsigned       pixels_sent;
    int unsigned       cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("tb_column_free_interval_cell_split: done, errors");
            $finish;
        end
    end

    // Result-side stalls
    always @(posedge clk)
        result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Result monitor
    always @(posedge clk)
        if (rst_n && result_if.valid === 1'b1 && result_if.ready)
            board.check_interval(result_if.payload);

    // Occupancy level on the chosen side of the threshold, often right at the edge
    function automatic logic [OCC_W-1:0] pick_level(bit is_free);
        if (is_free && thr_now != 0)
            return ($urandom_range(0, 3) == 0) ? thr_now - 1'b1
                                               : OCC_W'($urandom_range(thr_now - 1, 0));
        return ($urandom_range(0, 3) == 0) ? thr_now : OCC_W'($urandom_range(255, thr_now));
    endfunction

    // Free rows at first_row, first_row + 2, ... up to last_row
    function automatic logic [ROW_LIMIT-1:0] stripes(int first_row, int last_row);
        logic [ROW_LIMIT-1:0] m;
        m = '0;
        for (int r = first_row; r <= last_row; r += 2)
            m[r] = 1'b1;
        return m;
    endfunction

    task automatic send_pixel(input logic [OCC_W-1:0] occ, input bit start);
        pix_t p;
        p.occupancy = occ;
        p.map_start = start;
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                pixel_if.valid <= 1'b0;
                @(posedge clk);
            end
        pixel_if.valid   <= 1'b1;
        pixel_if.payload <= p;
        do
            @(posedge clk);
        while (pixel_if.ready !== 1'b1);
        board.take_pixel(p);
        pixels_sent++;
    endtask

    // One column from a free-row mask; stray_pct adds map starts inside the column
    task automatic send_column(input logic [ROW_LIMIT-1:0] m, input int unsigned n,
                               input bit start, input int unsigned stray_pct);
        for (int r = 0; r < n; r++)
            send_pixel(pick_level(m[r]),
                       (r == 0) ? start : ($urandom_range(0, 99) < stray_pct));
    endtask

    task automatic write_cfg(input logic [CFG_DAT_W-1:0] rows_val,
                             input logic [CFG_DAT_W-1:0] thr_val);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= cfg_t'{index: REG_ROWS_IN_USE, data: rows_val};
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        board.write_reg(REG_ROWS_IN_USE, rows_val);
        cfg_if.payload <= cfg_t'{index: REG_FREE_THRESHOLD, data: thr_val};
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        board.write_reg(REG_FREE_THRESHOLD, thr_val);
        cfg_if.valid <= 1'b0;
        thr_now = thr_val[THR_W-1:0];
    endtask

    // Wait for every expected item, then for any column end still in progress
    task automatic settle();
        pixel_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [ROW_LIMIT-1:0] mask;
        logic [ROW_LIMIT-1:0] last_mask;
        logic [CFG_DAT_W-1:0] rows_val;
        logic [CFG_DAT_W-1:0] thr_val;
        int unsigned          rows_eff;
        int unsigned          phase_start;
        int unsigned          kind;
        int unsigned          density;

        rst_n            = 1'b0;
        steady           = 1'b0;
        pixel_if.valid   = 1'b0;
        pixel_if.payload = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.payload   = '0;
        result_if.ready  = 1'b0;
        thr_now          = THRESH_RESET;
        pixels_sent      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Short columns: open, extend, two empty columns, all free, restart mid column
        write_cfg(11'd4, 11'd100);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd99, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_column('0, 4, 1'b0, 0);
        send_column('0, 4, 1'b0, 0);
        send_column('1, 4, 1'b0, 0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd50, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd99, 1'b0);
        settle();

        // Threshold zero: nothing is free
        write_cfg(11'd1, 11'd0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        settle();

        // Row count zero clamps to one; top threshold
        write_cfg(11'd0, 11'd255);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b0);
        settle();

        // Row count shrinks below the current row: next pixel closes the column
        write_cfg(11'd12, {3'b111, 8'd128});
        send_column(stripes(0, 6), 7, 1'b0, 0);
        settle();
        write_cfg(11'd3, 11'd128);
        send_pixel(pick_level(1'b1), 1'b0);
        send_column(stripes(1, 2), 3, 1'b0, 0);
        settle();

        // Interval store overflow with no stalls on either side;
        // the stored part of a long list can match a short one
        steady = 1'b1;
        write_cfg(11'd65, 11'd128);
        send_column(stripes(0, 64), 65, 1'b1, 0);
        send_column(stripes(0, 62), 65, 1'b0, 0);
        settle();
        steady = 1'b0;

        // Random phases: mostly repeated or fresh columns, some noise
        phase_start = pixels_sent;
        last_mask   = '0;
        while (pixels_sent - phase_start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                rows_eff = $urandom_range(1, 8);
            else if (kind < 92)
                rows_eff = $urandom_range(9, 24);
            else if (kind < 96)
                rows_eff = 0;
            else
                rows_eff = $urandom_range(65, 70);
            rows_val = CFG_DAT_W'(rows_eff);
            if (rows_eff == 0)
                rows_eff = 1;
            kind    = $urandom_range(0, 99);
            thr_val = {3'($urandom), 8'($urandom_range(1, 254))};
            if (kind < 15)
                thr_val[THR_W-1:0] = 8'd0;
            else if (kind < 30)
                thr_val[THR_W-1:0] = 8'd255;
            settle();
            write_cfg(rows_val, thr_val);
            for (int c = $urandom_range(3, 6);
                 c > 0 && pixels_sent - phase_start < RANDOM_ITEMS; c--)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 40)
                    mask = last_mask;
                else if (kind < 80)
                begin
                    density = $urandom_range(20, 80);
                    for (int r = 0; r < rows_eff; r++)
                        mask[r] = ($urandom_range(0, 99) < density);
                end
                else if (kind < 88)
                    mask = '1;
                else if (kind < 94)
                    mask = '0;
                else
                    mask = stripes($urandom_range(0, 1), rows_eff - 1);
                send_column(mask, rows_eff, $urandom_range(0, 99) < 8, 2);
                last_mask = mask;
            end
        end
        settle();

        $display("covered %0d pixels in %0d columns, thresholds 0..255, row counts 0..70",
                 pixels_sent, board.columns_done);
        $display("checked %0d intervals: %0d opening cells, %0d flagged overflow",
                 board.intervals_checked, board.new_cells, board.flagged);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_column_free_interval_cell_split: done, clean");
        else
            $display("tb_column_free_interval_cell_split: done, errors");
        $finish;
    end

endmodule
